@@ hdl/stis_pkg.sv @@
// ----------------------------------------------------------------------------
// stis_pkg
// shared types and constants of the sorted table insertion search unit
// ----------------------------------------------------------------------------
package stis_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
	localparam int VALUE_W     = 64;
	localparam int POS_W       = 11;

	typedef logic [COUNT_W-1:0] count_t;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_SEARCH = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_code_t;

	typedef enum logic {
		STATUS_DONE    = 1'b0,
		STATUS_DROPPED = 1'b1
	} status_t;

	typedef struct packed {
		logic [1:0]                command;
		logic signed [VALUE_W-1:0] value;
		logic                      right_side;
	} req_t;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic             status;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic step;
		logic load_out;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_search;
		logic count_zero;
		logic search_done;
	} dp_sts_t;

endpackage

@@ hdl/stis_ram.sv @@
// ----------------------------------------------------------------------------
// stis_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module stis_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                                        clk,
	input  logic                                        wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                            wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                            rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

@@ hdl/stis_datapath.sv @@
// ----------------------------------------------------------------------------
// stis_datapath
// entry count, table ram, binary search bounds and result register
// ----------------------------------------------------------------------------
module stis_datapath
	import stis_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  req_t    req,
	input  dp_cmd_t cmd,
	output dp_sts_t sts,
	output rsp_t    rsp
);

	count_t                    count_q;
	count_t                    low_q;
	count_t                    high_q;
	count_t                    probe_q;
	logic signed [VALUE_W-1:0] key_q;
	logic                      upper_q;
	count_t                    res_pos_q;
	logic                      res_status_q;
	rsp_t                      rsp_q;

	logic [VALUE_W-1:0]        rd_data;
	logic [ADDR_W-1:0]         rd_addr;
	logic                      wr_en;
	logic                      go_right;
	count_t                    nlow;
	count_t                    nhigh;
	count_t                    nprobe;
	count_t                    half_count;
	logic                      has_room;

	assign has_room   = (count_q < COUNT_W'(TABLE_DEPTH));
	assign half_count = count_q >> 1;

	// one probe per cycle: compare the word read last cycle, then narrow
	always_comb begin
		if (upper_q) begin
			go_right = ($signed(rd_data) <= key_q);
		end else begin
			go_right = ($signed(rd_data) < key_q);
		end
		nlow   = go_right ? (probe_q + count_t'(1)) : low_q;
		nhigh  = go_right ? high_q : probe_q;
		nprobe = nlow + ((nhigh - nlow) >> 1);
	end

	assign wr_en   = cmd.accept && (req.command == CMD_APPEND) && has_room;
	assign rd_addr = cmd.accept ? half_count[ADDR_W-1:0] : nprobe[ADDR_W-1:0];

	stis_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[ADDR_W-1:0]),
		.wr_data (req.value),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.accept) begin
			case (req.command)
				CMD_CLEAR:  count_q <= '0;
				CMD_APPEND: if (has_room) begin
					count_q <= count_q + count_t'(1);
				end
				default:    count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			res_status_q <= STATUS_DONE;
			res_pos_q    <= count_q;
			case (req.command)
				CMD_CLEAR: begin
					res_pos_q <= '0;
				end
				CMD_APPEND: begin
					if (has_room) begin
						res_pos_q <= count_q + count_t'(1);
					end else begin
						res_status_q <= STATUS_DROPPED;
					end
				end
				CMD_SEARCH: begin
					res_pos_q <= '0;
					low_q     <= '0;
					high_q    <= count_q;
					probe_q   <= half_count;
					key_q     <= req.value;
					upper_q   <= req.right_side;
				end
				default: begin
					res_pos_q <= count_q;
				end
			endcase
		end else if (cmd.step) begin
			low_q     <= nlow;
			high_q    <= nhigh;
			probe_q   <= nprobe;
			res_pos_q <= nlow;
		end
		if (cmd.load_out) begin
			rsp_q.position <= POS_W'(res_pos_q);
			rsp_q.status   <= res_status_q;
		end
	end

	assign sts.is_search   = (req.command == CMD_SEARCH);
	assign sts.count_zero  = (count_q == '0);
	assign sts.search_done = !(nlow < nhigh);
	assign rsp             = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(TABLE_DEPTH))
		else $error("entry count above table depth");

	a_bounds_open: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (low_q < high_q))
		else $error("search step with empty interval");

	a_probe_inside: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (probe_q >= low_q) && (probe_q < high_q))
		else $error("probe outside search interval");

endmodule

@@ hdl/stis_ctrl.sv @@
// ----------------------------------------------------------------------------
// stis_ctrl
// sequencer for accept, search steps and result transfer
// ----------------------------------------------------------------------------
module stis_ctrl
	import stis_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	output logic    req_stall,
	output logic    rsp_valid,
	input  logic    rsp_stall,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					if (sts.is_search && !sts.count_zero) begin
						state_d = ST_SEARCH;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_SEARCH: begin
				cmd.step = 1'b1;
				if (sts.search_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	a_short_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && !sts.is_search |=> state_q == ST_FINISH)
		else $error("non-search item did not go straight to finish");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q)
		else $error("result loaded but not presented");

endmodule

@@ hdl/sorted_table_insertion_search_unit.sv @@
// ----------------------------------------------------------------------------
// sorted_table_insertion_search_unit
// table of signed 64-bit entries with append, clear and binary search
// ----------------------------------------------------------------------------
// usage
//   req channel (req_valid / req_stall / req): one item per transfer, command
//   clear, append or search; value is the entry or the search key, right_side
//   picks first-greater instead of first-not-less
//   rsp channel (rsp_valid / rsp_stall / rsp): exactly one result per item,
//   position (count after append or clear, insertion index for a search) and
//   status (set when an append hits a full table)
// processing
//   clear, append and unused codes: accepted in idle, then the result is
//   loaded into the output register from the finish state
//   search: at most floor(log2(count)) + 1 probes; the ram read and compare
//   loop runs one probe per cycle through the registered read port, and the
//   result is then loaded from the finish state as above
//   one item is in flight at a time; req_stall is high while it is worked on
// reset
//   entry count clears, the table contents are left as they are
// receiver stall
//   the finished result waits in the output register; the next item is taken
//   only once that register has been loaded
// ----------------------------------------------------------------------------
module sorted_table_insertion_search_unit
	import stis_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	// command and status between the sequencer and the datapath
	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequencer: accept, one search step per cycle, result transfer
	stis_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: count, table ram, search bounds, output register
	stis_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule
